[sv/phe_pkg.sv]
// ----------------------------------------------------------------------------
// phe_pkg
// Constants and types shared by the pixel histogram engine.
// ----------------------------------------------------------------------------
package phe_pkg;

  localparam int DEF_MAX_BINS   = 256;
  localparam int DEF_COUNT_BITS = 32;
  localparam int DIRECT_BINS    = 256;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_LEVELS   = 2'd0,
    REG_RANGE_MIN    = 2'd1,
    REG_RANGE_LENGTH = 2'd2,
    REG_DIRECT_MODE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_RD,
    PH_WB
  } phase_t;

endpackage

[sv/pixel_histogram_engine.sv]
// ----------------------------------------------------------------------------
// pixel_histogram_engine
// Bin table histogram with add and read-and-clear items.
// ----------------------------------------------------------------------------
// Result path: a read item goes through the table read and write-back states,
//   then its result is registered onto the ports. Items: one at a time
//   (accept, table read, write back); a scaled add above range_min also runs
//   the restoring divider, which resolves one quotient bit per cycle.
// Reset: control and config registers take reset values; a clearing pass
//   sweeps all table RAM entries with busy high. Results cannot stall.
module pixel_histogram_engine
  import phe_pkg::*;
#(
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic signed [15:0]    in_sample_value,
  input  logic [7:0]            in_bin_index,
  output logic                  out_valid,
  output logic [31:0]           out_bin_count,
  output logic [7:0]            out_bin_number,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int LW = $clog2(MAX_BINS + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam int QW = LW + 17;
  localparam int CW = $clog2(QW);

  logic [8:0]         lv_cfg_r;
  logic signed [15:0] rmin_r;
  logic [15:0]        rlen_r;
  logic               dm_r;

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [COUNT_BITS-1:0] rdata_r;

  state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [AW:0]  clr_r, clr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic op_r, op_nxt, hit_r, hit_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [QW-1:0] num_r, num_nxt;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] lv_r, lv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_count_r, out_count_nxt;
  logic [7:0]  out_num_r, out_num_nxt;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [LW-1:0]  lv_eff;
  logic signed [17:0] d;
  logic [16:0]    den;
  logic [QW:0]    trial;
  logic [QW-1:0]  quo;
  logic           direct_clip;
  logic [7:0]     dbin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_cfg_r <= 9'd256;
      rmin_r   <= '0;
      rlen_r   <= 16'd255;
      dm_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIN_LEVELS:   lv_cfg_r <= cfg_data[8:0];
        REG_RANGE_MIN:    rmin_r   <= signed'(cfg_data);
        REG_RANGE_LENGTH: rlen_r   <= cfg_data;
        REG_DIRECT_MODE:  dm_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lv_cfg_r < 9'd2) lv_eff = LW'(2);
    else if (32'(lv_cfg_r) > MAX_BINS) lv_eff = LW'(MAX_BINS);
    else lv_eff = LW'(lv_cfg_r);
    d   = 18'(in_sample_value) - 18'(rmin_r);
    den = {1'b0, rlen_r} + 17'd1;
    trial = {rem_r, num_r[QW-1]} - {{(QW-16){1'b0}}, den};
    quo   = {num_r[QW-2:0], ~trial[QW]};
    if (in_sample_value < 0) dbin = 8'd0;
    else if (in_sample_value > 16'(DIRECT_BINS - 1)) dbin = 8'(DIRECT_BINS - 1);
    else dbin = in_sample_value[7:0];
    direct_clip = 32'(dbin) > MAX_BINS - 1;
  end

  // restoring divider for a QW-bit quotient, one quotient bit per cycle
  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; clr_nxt = clr_r;
    addr_nxt = addr_r; op_nxt = op_r; hit_nxt = hit_r; idx_nxt = idx_r;
    num_nxt = num_r; rem_nxt = rem_r; lv_nxt = lv_r; cnt_nxt = cnt_r;
    out_valid_nxt = 1'b0; out_count_nxt = out_count_r; out_num_nxt = out_num_r;
    we = 1'b0; waddr = addr_r; wdata = '0;
    case (st_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == MAX_BINS - 1) st_nxt = ST_RUN;
      end
      ST_RUN: begin
        case (ph_r)
          PH_IDLE: begin
            if (start) begin
              op_nxt = in_op; idx_nxt = in_bin_index; lv_nxt = lv_eff;
              hit_nxt = 1'b1;
              if (op_t'(in_op) == OP_READ) begin
                hit_nxt = 32'(in_bin_index) < MAX_BINS;
                addr_nxt = AW'(in_bin_index);
                ph_nxt = PH_RD;
              end else if (dm_r) begin
                addr_nxt = direct_clip ? AW'(MAX_BINS - 1) : AW'(dbin);
                ph_nxt = PH_RD;
              end else if (d <= 0) begin
                addr_nxt = '0; ph_nxt = PH_RD;
              end else begin
                num_nxt = QW'(lv_eff) * QW'(d[16:0]);
                rem_nxt = '0; cnt_nxt = '0; ph_nxt = PH_DIV;
              end
            end
          end
          PH_DIV: begin
            if (!trial[QW]) rem_nxt = trial[QW-1:0];
            else rem_nxt = {rem_r[QW-2:0], num_r[QW-1]};
            num_nxt = quo;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == CW'(QW - 1)) begin
              addr_nxt = (quo >= QW'(lv_r)) ? AW'(lv_r - 1'b1) : AW'(quo);
              ph_nxt = PH_RD;
            end
          end
          PH_RD: begin
            ph_nxt = PH_WB;
          end
          PH_WB: begin
            we = hit_r;
            if (op_r) begin
              wdata = '0;
              out_valid_nxt = 1'b1;
              out_num_nxt = idx_r;
              if (!hit_r) out_count_nxt = 32'd0;
              else if (COUNT_BITS > 32 && rdata_r > COUNT_BITS'(32'hFFFF_FFFF))
                out_count_nxt = 32'hFFFF_FFFF;
              else out_count_nxt = 32'(rdata_r);
            end else begin
              wdata = (rdata_r == CMAX) ? rdata_r : rdata_r + 1'b1;
            end
            ph_nxt = PH_IDLE;
          end
          default: ph_nxt = PH_IDLE;
        endcase
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; ph_r <= PH_IDLE; clr_r <= '0; out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; clr_r <= clr_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    op_r <= op_nxt; hit_r <= hit_nxt; idx_r <= idx_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; lv_r <= lv_nxt; cnt_r <= cnt_nxt;
    out_count_r <= out_count_nxt; out_num_r <= out_num_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ph_r == PH_RD) rdata_r <= mem[addr_r];
  end

  assign busy           = (st_r != ST_RUN) || (ph_r != PH_IDLE);
  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_count_r;
  assign out_bin_number = out_num_r;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> busy) else $error("accepted during clear");
  a_result_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ph_r == PH_WB && op_r)) else $error("stray result");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

endmodule

[bench/phe_checker.sv]
// ----------------------------------------------------------------------------
// phe_checker
// Watches the item and result channels of the pixel histogram engine, keeps
// its own bin table and register copy, and compares every result against the
// oldest expected bin read.
// ----------------------------------------------------------------------------
module phe_checker
  import phe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_op,
  input  logic signed [15:0]    in_sample_value,
  input  logic [7:0]            in_bin_index,
  input  logic                  out_valid,
  input  logic [31:0]           out_bin_count,
  input  logic [7:0]            out_bin_number,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  number;
  } bin_read_t;

  logic [31:0]        table_model [256];
  logic [8:0]         levels_q;
  logic signed [15:0] min_q;
  logic [15:0]        length_q;
  logic               direct_q;
  bin_read_t          read_fifo [16];
  int                 rd_ptr;
  int                 wr_ptr;

  function automatic logic [7:0] bin_of(logic signed [15:0] v);
    longint d, q, lv;
    if (direct_q) begin
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    end
    lv = levels_q;
    if (lv < 2) lv = 2;
    if (lv > 256) lv = 256;
    d = longint'(v) - longint'(min_q);
    if (d <= 0) return 8'd0;
    q = (lv * d) / (longint'(length_q) + 1);
    if (q > lv - 1) q = lv - 1;
    return q[7:0];
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_reads = wr_ptr - rd_ptr;

  always @(posedge clk) begin
    logic [7:0] b;
    bin_read_t  e;
    if (!rst_n) begin
      foreach (table_model[i]) table_model[i] = '0;
      levels_q = 9'd256;
      min_q = '0;
      length_q = 16'd255;
      direct_q = 1'b1;
      rd_ptr = 0;
      wr_ptr = 0;
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (wr_ptr == rd_ptr) begin
          report($sformatf("unexpected result bin %0d count %0d", out_bin_number, out_bin_count));
        end else begin
          e = read_fifo[rd_ptr[3:0]];
          rd_ptr++;
          if (out_bin_count !== e.count)
            report($sformatf("bin %0d count %0d, want %0d", e.number, out_bin_count, e.count));
          if (out_bin_number !== e.number)
            report($sformatf("bin number %0d, want %0d", out_bin_number, e.number));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_BIN_LEVELS:   levels_q = cfg_data[8:0];
          REG_RANGE_MIN:    min_q = cfg_data;
          REG_RANGE_LENGTH: length_q = cfg_data;
          REG_DIRECT_MODE:  direct_q = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (op_t'(in_op) == OP_ADD) begin
          b = bin_of(in_sample_value);
          if (table_model[b] != 32'hFFFF_FFFF) table_model[b]++;
        end else begin
          e.count = table_model[in_bin_index];
          e.number = in_bin_index;
          table_model[in_bin_index] = '0;
          read_fifo[wr_ptr[3:0]] = e;
          wr_ptr++;
        end
      end
    end
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random add and read items with bursty gaps through
// several register settings, then gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import phe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = 1'b0;
  logic signed [15:0]    in_sample_value = '0;
  logic [7:0]            in_bin_index = '0;
  logic                  out_valid;
  logic [31:0]           out_bin_count;
  logic [7:0]            out_bin_number;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending_reads;
  int                    idle_cycles = 0;

  always #2 clk = ~clk;

  pixel_histogram_engine dut (.*);
  phe_checker u_checker (.*);

  always @(posedge clk) begin
    if (start && !busy || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic signed [15:0] v, logic [7:0] idx);
    start <= 1'b1;
    in_op <= op;
    in_sample_value <= v;
    in_bin_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 6);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] d);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic drain_all();
    for (int i = 0; i < 256; i++) send_item(OP_READ, '0, i[7:0]);
    settle();
  endtask

  task automatic random_phase(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_READ, 16'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        send_item(OP_ADD, 16'($urandom), 8'($urandom));
      end else begin
        send_item(OP_ADD, 16'($urandom_range(0, 300) - 20), 8'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(OP_ADD, 16'sh8000, 8'h00);
    send_item(OP_ADD, 16'sh7FFF, 8'hFF);
    send_item(OP_ADD, -16'sd1, 8'h00);
    send_item(OP_ADD, 16'sd256, 8'h00);
    send_item(OP_ADD, 16'sd255, 8'h00);
    send_item(OP_ADD, 16'sd0, 8'h00);
    send_item(OP_ADD, 16'sd0, 8'h00);
    send_item(OP_READ, 16'sh7FFF, 8'h00);
    send_item(OP_READ, 16'sh8000, 8'hFF);
    send_item(OP_READ, '0, 8'h00);
    send_item(OP_ADD, 16'sd37, 8'h00);
    send_item(OP_READ, '0, 8'd37);
    settle();
    write_reg(REG_DIRECT_MODE, 16'd0);
    write_reg(REG_BIN_LEVELS, 16'd0);
    write_reg(REG_RANGE_MIN, 16'h8000);
    write_reg(REG_RANGE_LENGTH, 16'hFFFF);
    send_item(OP_ADD, 16'sh8000, 8'h00);
    send_item(OP_ADD, 16'sh7FFF, 8'h00);
    send_item(OP_ADD, 16'sh0000, 8'h00);
    send_item(OP_READ, '0, 8'd0);
    send_item(OP_READ, '0, 8'd1);
    settle();
    write_reg(REG_BIN_LEVELS, 16'h01FF);
    write_reg(REG_RANGE_MIN, 16'h7FFF);
    write_reg(REG_RANGE_LENGTH, 16'd0);
    send_item(OP_ADD, 16'sh8000, 8'h00);
    send_item(OP_ADD, 16'sh7FFF, 8'h00);
    settle();
    drain_all();
    random_phase(250);
    write_reg(REG_BIN_LEVELS, 16'd256);
    write_reg(REG_RANGE_MIN, 16'hFFEC);
    write_reg(REG_RANGE_LENGTH, 16'd299);
    random_phase(300);
    write_reg(REG_BIN_LEVELS, 16'd2);
    write_reg(REG_RANGE_LENGTH, 16'd0);
    random_phase(150);
    write_reg(REG_BIN_LEVELS, 16'd17);
    write_reg(REG_RANGE_MIN, 16'h8000);
    write_reg(REG_RANGE_LENGTH, 16'd400);
    random_phase(250);
    write_reg(REG_BIN_LEVELS, 16'd100);
    write_reg(REG_RANGE_MIN, 16'd0);
    write_reg(REG_RANGE_LENGTH, 16'd65535);
    random_phase(200);
    write_reg(REG_DIRECT_MODE, 16'd1);
    random_phase(250);
    drain_all();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
